// ===== sv/arq_send_window_assert.svh =====
// Assertion helpers shared by the send window modules.
// Both forms expect a clock named clk and an active high reset named rst.
`ifndef ARQ_SEND_WINDOW_ASSERT_SVH
`define ARQ_SEND_WINDOW_ASSERT_SVH
`ifndef SYNTHESIS
`define ARQSW_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define ARQSW_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`else
`define ARQSW_ASSERT(lbl, prop, msg)
`define ARQSW_ASSERT_IMPL(lbl, ante, cons, msg)
`endif
`endif

// ===== sv/arqsw_pkg.sv =====
package arqsw_pkg;

  localparam int MAX_SLOTS_DEF     = 64;
  localparam int MAX_PDU_BYTES_DEF = 1024;
  localparam int WINDOW_RESET      = 64;

  localparam int MODE_W = 3;
  localparam int SEQ_W  = 32;
  localparam int BYTE_W = 8;
  localparam int OFF_W  = 10;
  localparam int LEN_W  = 11;
  localparam int WIN_W  = 7;
  localparam int ATT_W  = 8;
  localparam int ACK_W  = 7;

  localparam logic [ATT_W-1:0] ATT_MAX = '1;

  typedef enum logic [MODE_W-1:0] {
    M_WRITE    = 3'd0,
    M_COMMIT   = 3'd1,
    M_RR       = 3'd2,
    M_SREJ     = 3'd3,
    M_READ_SEQ = 3'd4,
    M_READ_LOW = 3'd5
  } mode_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_INDEX,
    S_ACCESS,
    S_FINISH,
    S_MSTART,
    S_MWAIT
  } state_t;

  typedef struct packed {
    logic [SEQ_W-1:0] seq;
    logic [LEN_W-1:0] length;
    logic [ATT_W-1:0] attempts;
  } slot_entry_t;

  typedef struct packed {
    logic             start;
    logic [SEQ_W-1:0] dividend;
    logic [WIN_W-1:0] divisor;
  } mod_req_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [WIN_W-1:0] rem;
  } mod_rsp_t;

endpackage

// ===== sv/arqsw_ifs.sv =====
interface arqsw_req_if;
  logic                          valid;
  logic                          ready;
  logic [arqsw_pkg::MODE_W-1:0]  mode;
  logic [arqsw_pkg::SEQ_W-1:0]   seq;
  logic [arqsw_pkg::BYTE_W-1:0]  data_byte;
  logic [arqsw_pkg::OFF_W-1:0]   byte_offset;
  logic [arqsw_pkg::LEN_W-1:0]   pdu_length;

  modport source (output valid, mode, seq, data_byte, byte_offset, pdu_length,
                  input ready);
  modport sink (input valid, mode, seq, data_byte, byte_offset, pdu_length,
                output ready);
endinterface

interface arqsw_rsp_if;
  logic                          valid;
  logic                          ready;
  logic                          status;
  logic [arqsw_pkg::ACK_W-1:0]   ack_count;
  logic                          window_open;
  logic [arqsw_pkg::SEQ_W-1:0]   found_seq;
  logic [arqsw_pkg::LEN_W-1:0]   found_length;
  logic [arqsw_pkg::ATT_W-1:0]   attempt_count;
  logic [arqsw_pkg::BYTE_W-1:0]  data_out;

  modport source (output valid, status, ack_count, window_open, found_seq, found_length,
                  attempt_count, data_out, input ready);
  modport sink (input valid, status, ack_count, window_open, found_seq, found_length,
                attempt_count, data_out, output ready);
endinterface

interface arqsw_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [arqsw_pkg::WIN_W-1:0]  window_size;

  modport source (output valid, window_size, input ready);
  modport sink (input valid, window_size, output ready);
endinterface

// ===== sv/arqsw_slot_ram.sv =====
module arqsw_slot_ram #(
  parameter int DEPTH = arqsw_pkg::MAX_SLOTS_DEF,
  parameter int AW    = 6
) (
  input  logic                   clk,
  input  logic                   we,
  input  logic                   re,
  input  logic [AW-1:0]          addr,
  input  arqsw_pkg::slot_entry_t wdata,
  output arqsw_pkg::slot_entry_t rdata
);
  import arqsw_pkg::*;

  slot_entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

// ===== sv/arqsw_pay_ram.sv =====
module arqsw_pay_ram #(
  parameter int DEPTH = arqsw_pkg::MAX_SLOTS_DEF * arqsw_pkg::MAX_PDU_BYTES_DEF,
  parameter int AW    = 16
) (
  input  logic                         clk,
  input  logic                         we,
  input  logic                         re,
  input  logic [AW-1:0]                addr,
  input  logic [arqsw_pkg::BYTE_W-1:0] wdata,
  output logic [arqsw_pkg::BYTE_W-1:0] rdata
);
  import arqsw_pkg::*;

  logic [BYTE_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

// ===== sv/arqsw_mod.sv =====
`include "arq_send_window_assert.svh"

// Serial remainder: one dividend bit per cycle, restoring form.
module arqsw_mod (
  input  logic                clk,
  input  logic                rst,
  input  arqsw_pkg::mod_req_t mreq,
  output arqsw_pkg::mod_rsp_t mrsp
);
  import arqsw_pkg::*;

  localparam int CNT_W = $clog2(SEQ_W) + 1;

  logic             busy;
  logic             done;
  logic [CNT_W-1:0] cnt;
  logic [SEQ_W-1:0] dvd;
  logic [WIN_W-1:0] dvs;
  logic [WIN_W-1:0] rem;
  logic [WIN_W:0]   shifted;
  logic [WIN_W:0]   trial;

  assign shifted = {rem, dvd[SEQ_W-1]};
  assign trial   = shifted - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (mreq.start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(SEQ_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // rem stays below the divisor, so the trial value always fits
  always_ff @(posedge clk) begin
    if (mreq.start) begin
      dvd <= mreq.dividend;
      dvs <= mreq.divisor;
      rem <= '0;
    end else if (busy) begin
      dvd <= dvd << 1;
      rem <= (shifted >= {1'b0, dvs}) ? trial[WIN_W-1:0] : shifted[WIN_W-1:0];
    end
  end

  assign mrsp.busy = busy;
  assign mrsp.done = done;
  assign mrsp.rem  = rem;

  `ARQSW_ASSERT_IMPL(a_no_restart, mreq.start, !busy, "remainder unit restarted while busy")
  `ARQSW_ASSERT_IMPL(a_rem_below, done, rem < dvs, "remainder not below divisor")
  `ARQSW_ASSERT_IMPL(a_dvs_nonzero, busy, dvs != '0, "remainder unit running with zero divisor")

endmodule

// ===== sv/arq_send_window.sv =====
// Selective-repeat send window.
// Channels: req carries one request (mode, seq, data_byte, byte_offset,
// pdu_length), rsp returns exactly one result per request, cfg writes the
// window size. All three use valid/ready; a transfer happens on an edge
// with both high.
// Each request walks check, index, slot access and finish; rsp.valid rises
// when finish loads the output register, and the next request is taken
// once the state machine is back in idle. Slot table and payload RAMs have
// registered reads; a request makes at most one access to each, except an
// SREJ hit, which reads its slot and writes it back. An RR whose window
// slide wraps the slot ring more than once, and every cfg write, recompute
// the lowest slot in the serial remainder unit; req and cfg are held off.
// Reset: window 64 (clamped to MAX_SLOTS), window empty, sequence numbers
// zero, slot valid bits cleared at once, no clearing pass of the RAMs.
// If rsp is stalled the finished result waits in the finish stage and no
// new request is accepted until the output register has room.
`include "arq_send_window_assert.svh"

module arq_send_window #(
  parameter int MAX_SLOTS     = arqsw_pkg::MAX_SLOTS_DEF,
  parameter int MAX_PDU_BYTES = arqsw_pkg::MAX_PDU_BYTES_DEF
) (
  input logic         clk,
  input logic         rst,
  arqsw_cfg_if.sink   cfg,
  arqsw_req_if.sink   req,
  arqsw_rsp_if.source rsp
);
  import arqsw_pkg::*;

  localparam int SLOT_W    = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
  localparam int PAY_DEPTH = MAX_SLOTS * MAX_PDU_BYTES;
  localparam int PAY_AW    = (PAY_DEPTH > 1) ? $clog2(PAY_DEPTH) : 1;
  localparam logic [WIN_W-1:0] WIN_RESET =
    WIN_W'((MAX_SLOTS < WINDOW_RESET) ? MAX_SLOTS : WINDOW_RESET);

  state_t state, state_next;

  // request registers
  logic [MODE_W-1:0] op;
  logic [SEQ_W-1:0]  seq_r;
  logic [BYTE_W-1:0] byte_r;
  logic [OFF_W-1:0]  off_r;
  logic [LEN_W-1:0]  len_r;
  logic              go;
  logic              rr_noop;
  logic [WIN_W-1:0]  dsel;
  logic [SLOT_W-1:0] idx;

  // window state
  logic [SEQ_W-1:0]     lower_seq;
  logic [SEQ_W-1:0]     next_seq;
  logic [WIN_W-1:0]     lower_slot;
  logic [WIN_W-1:0]     cnt;
  logic [WIN_W-1:0]     win;
  logic [MAX_SLOTS-1:0] valid;
  logic [MAX_SLOTS-1:0] clr_mask;

  // output register
  logic              out_vld;
  logic              out_status;
  logic [ACK_W-1:0]  out_ack;
  logic              out_open;
  logic [SEQ_W-1:0]  out_seq;
  logic [LEN_W-1:0]  out_len;
  logic [ATT_W-1:0]  out_att;
  logic [BYTE_W-1:0] out_data;
  logic              out_load;
  logic              fin_fire;

  // check stage
  logic [SEQ_W-1:0] diff;
  logic             ge_lower;
  logic             le_next;
  logic             lt_next;
  logic             in_win;
  logic             is_open;
  logic             off_ok;
  logic             chk_go;
  logic [WIN_W-1:0] chk_dsel;

  // index stage
  logic [WIN_W:0] isum;
  logic [WIN_W:0] idx_calc;

  // finish stage
  slot_entry_t       slot_rd;
  logic [BYTE_W-1:0] pay_rd;
  logic              vld;
  logic              hit;
  logic              fin_status;
  logic [ACK_W-1:0]  fin_ack;
  logic              fin_emit;
  logic [WIN_W-1:0]  cnt_after;
  logic [WIN_W:0]    rsum;
  logic [WIN_W:0]    rdiff;
  logic [WIN_W-1:0]  slot_after;
  logic              need_mod;
  logic [ATT_W-1:0]  att_inc;

  // memory controls
  logic              s_we;
  logic              s_re;
  slot_entry_t       s_wdata;
  logic              p_we;
  logic              p_re;
  logic [PAY_AW-1:0] p_addr;

  mod_req_t         mreq;
  mod_rsp_t         mrsp;
  logic [WIN_W-1:0] win_cfg;

  assign cfg.ready = (state == S_IDLE);
  assign req.ready = (state == S_IDLE) && !cfg.valid;
  assign out_load  = !out_vld || rsp.ready;
  assign fin_fire  = (state == S_FINISH) && out_load;
  assign off_ok    = 32'(off_r) < MAX_PDU_BYTES;

  always_comb begin
    if (cfg.window_size == '0) begin
      win_cfg = WIN_W'(1);
    end else if (32'(cfg.window_size) > MAX_SLOTS) begin
      win_cfg = WIN_W'(MAX_SLOTS);
    end else begin
      win_cfg = cfg.window_size;
    end
  end

  // ---------------- check ----------------
  always_comb begin
    diff     = seq_r - lower_seq;
    ge_lower = seq_r >= lower_seq;
    le_next  = seq_r <= next_seq;
    lt_next  = seq_r < next_seq;
    in_win   = ge_lower && (diff[SEQ_W-1:WIN_W] == '0) && (diff[WIN_W-1:0] < win);
    is_open  = cnt < win;
    chk_go   = 1'b0;
    chk_dsel = diff[WIN_W-1:0];
    case (mode_t'(op)) inside
      M_WRITE: begin
        chk_go   = is_open && off_ok;
        chk_dsel = cnt;
      end
      M_COMMIT: begin
        chk_go   = (32'(len_r) <= MAX_PDU_BYTES) && (seq_r == next_seq) && is_open
                   && (next_seq != '1);
        chk_dsel = cnt;
      end
      M_RR:                  chk_go = !(seq_r <= lower_seq) && le_next;
      M_SREJ:                chk_go = in_win && lt_next;
      M_READ_SEQ:            chk_go = in_win;
      M_READ_LOW: begin
        chk_go   = cnt != '0;
        chk_dsel = '0;
      end
      default:               chk_go = 1'b0;
    endcase
  end

  // ---------------- index: offset within window fits one subtract ----------------
  always_comb begin
    isum     = {1'b0, lower_slot} + {1'b0, dsel};
    idx_calc = (isum >= {1'b0, win}) ? isum - {1'b0, win} : isum;
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      op     <= req.mode;
      seq_r  <= req.seq;
      byte_r <= req.data_byte;
      off_r  <= req.byte_offset;
      len_r  <= req.pdu_length;
    end
    if (state == S_CHECK) begin
      go      <= chk_go;
      rr_noop <= seq_r <= lower_seq;
      dsel    <= chk_dsel;
    end
    if (state == S_INDEX) begin
      idx <= SLOT_W'(idx_calc);
    end
  end

  // ---------------- memories ----------------
  assign p_addr = PAY_AW'(32'(idx) * MAX_PDU_BYTES + 32'(off_r));
  assign att_inc = (slot_rd.attempts == ATT_MAX) ? ATT_MAX : slot_rd.attempts + 1'b1;

  always_comb begin
    s_we    = 1'b0;
    s_re    = 1'b0;
    s_wdata = '{seq: seq_r, length: len_r, attempts: ATT_W'(1)};
    p_we    = 1'b0;
    p_re    = 1'b0;
    if (state == S_ACCESS) begin
      case (mode_t'(op)) inside
        M_COMMIT: s_we = go;
        M_WRITE:  p_we = go;
        M_SREJ:   s_re = go;
        M_READ_SEQ, M_READ_LOW: begin
          s_re = go;
          p_re = go && off_ok;
        end
        default: ;
      endcase
    end else if (fin_fire && (mode_t'(op) == M_SREJ) && hit) begin
      s_we    = 1'b1;
      s_wdata = '{seq: slot_rd.seq, length: slot_rd.length, attempts: att_inc};
    end
  end

  arqsw_slot_ram #(
    .DEPTH (MAX_SLOTS),
    .AW    (SLOT_W)
  ) u_slot_ram (
    .clk   (clk),
    .we    (s_we),
    .re    (s_re),
    .addr  (idx),
    .wdata (s_wdata),
    .rdata (slot_rd)
  );

  arqsw_pay_ram #(
    .DEPTH (PAY_DEPTH),
    .AW    (PAY_AW)
  ) u_pay_ram (
    .clk   (clk),
    .we    (p_we),
    .re    (p_re),
    .addr  (p_addr),
    .wdata (byte_r),
    .rdata (pay_rd)
  );

  // ---------------- finish ----------------
  always_comb begin
    vld        = valid[idx];
    hit        = 1'b0;
    fin_status = 1'b1;
    fin_ack    = '0;
    fin_emit   = 1'b0;
    cnt_after  = cnt;
    case (mode_t'(op)) inside
      M_WRITE: fin_status = !go;
      M_COMMIT: begin
        fin_status = !go;
        if (go) begin
          cnt_after = cnt + 1'b1;
        end
      end
      M_RR: begin
        if (rr_noop) begin
          fin_status = 1'b0;
        end else if (go) begin
          fin_status = 1'b0;
          fin_ack    = ACK_W'(dsel);
          cnt_after  = cnt - dsel;
        end
      end
      M_SREJ: begin
        hit        = go && vld && (slot_rd.seq == seq_r);
        fin_status = !hit;
      end
      M_READ_SEQ: begin
        hit        = go && vld && (slot_rd.seq == seq_r);
        fin_status = !hit;
        fin_emit   = hit;
      end
      M_READ_LOW: begin
        hit        = go && vld;
        fin_status = !hit;
        fin_emit   = hit;
      end
      default: ;
    endcase
  end

  // new lowest slot after an RR; if lowest slot plus slide reaches twice the window it goes serial
  always_comb begin
    rsum       = {1'b0, lower_slot} + {1'b0, dsel};
    rdiff      = rsum - {1'b0, win};
    slot_after = (rsum < {1'b0, win}) ? rsum[WIN_W-1:0] : rdiff[WIN_W-1:0];
    need_mod   = (mode_t'(op) == M_RR) && go && (rsum >= {win, 1'b0});
  end

  always_comb begin
    int rel;
    clr_mask = '0;
    for (int i = 0; i < MAX_SLOTS; i++) begin
      rel = (i >= int'(lower_slot)) ? i - int'(lower_slot)
                                    : i + int'(win) - int'(lower_slot);
      clr_mask[i] = (dsel >= win) || ((i < int'(win)) && (rel < int'(dsel)));
    end
  end

  // ---------------- state machine ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next    = state;
    mreq.start    = 1'b0;
    mreq.dividend = lower_seq;
    mreq.divisor  = win;
    unique case (state)
      S_IDLE: begin
        if (cfg.valid) begin
          state_next = S_MSTART;
        end else if (req.valid) begin
          state_next = S_CHECK;
        end
      end
      S_CHECK:  state_next = S_INDEX;
      S_INDEX:  state_next = S_ACCESS;
      S_ACCESS: state_next = S_FINISH;
      S_FINISH: begin
        if (out_load) begin
          state_next = need_mod ? S_MSTART : S_IDLE;
        end
      end
      S_MSTART: begin
        mreq.start = 1'b1;
        state_next = S_MWAIT;
      end
      S_MWAIT: begin
        if (mrsp.done) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  arqsw_mod u_mod (
    .clk  (clk),
    .rst  (rst),
    .mreq (mreq),
    .mrsp (mrsp)
  );

  // ---------------- window state ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      lower_seq  <= '0;
      next_seq   <= '0;
      lower_slot <= '0;
      cnt        <= '0;
      win        <= WIN_RESET;
      valid      <= '0;
    end else begin
      if (cfg.valid && cfg.ready) begin
        win <= win_cfg;
      end
      if ((state == S_MWAIT) && mrsp.done) begin
        lower_slot <= mrsp.rem;
      end
      if (fin_fire && go) begin
        case (mode_t'(op))
          M_COMMIT: begin
            valid[idx] <= 1'b1;
            next_seq   <= next_seq + 1'b1;
            cnt        <= cnt_after;
          end
          M_RR: begin
            valid      <= valid & ~clr_mask;
            lower_seq  <= seq_r;
            cnt        <= cnt_after;
            lower_slot <= slot_after;
          end
          default: ;
        endcase
      end
    end
  end

  // ---------------- output register ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (fin_fire) begin
      out_vld <= 1'b1;
    end else if (rsp.ready) begin
      out_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fin_fire) begin
      out_status <= fin_status;
      out_ack    <= fin_ack;
      out_open   <= cnt_after < win;
      out_seq    <= fin_emit ? slot_rd.seq : '0;
      out_len    <= fin_emit ? slot_rd.length : '0;
      out_att    <= fin_emit ? slot_rd.attempts : '0;
      out_data   <= (fin_emit && off_ok) ? pay_rd : '0;
    end
  end

  assign rsp.valid         = out_vld;
  assign rsp.status        = out_status;
  assign rsp.ack_count     = out_ack;
  assign rsp.window_open   = out_open;
  assign rsp.found_seq     = out_seq;
  assign rsp.found_length  = out_len;
  assign rsp.attempt_count = out_att;
  assign rsp.data_out      = out_data;

  `ARQSW_ASSERT(a_cnt_tracks, (next_seq - lower_seq) == SEQ_W'(cnt), "outstanding count out of step")
  `ARQSW_ASSERT(a_win_range, (win != '0) && (32'(win) <= MAX_SLOTS), "window size out of range")
  `ARQSW_ASSERT_IMPL(a_low_slot, state == S_IDLE, lower_slot < win, "lowest slot outside window")
  `ARQSW_ASSERT_IMPL(a_rsp_src, $rose(rsp.valid), $past(state) == S_FINISH, "result not from finish")

endmodule

// ===== verif/arq_send_window_tb.sv =====
`timescale 1ns / 100ps

module arq_send_window_tb;
  import arqsw_pkg::*;

  localparam int PDU_BYTES = MAX_PDU_BYTES_DEF;
  localparam int SLOTS = MAX_SLOTS_DEF;
  localparam int ACK_CAP = 2**ACK_W - 1;
  localparam int IDLE_LIMIT = 2000;
  localparam int PHASE_OPS = 85;
  localparam int PHASES = 8;
  localparam int SREJ_BURST = 258;
  localparam logic [MODE_W-1:0] M_SPARE_LO = 3'd6;
  localparam logic [MODE_W-1:0] M_SPARE_HI = 3'd7;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [SEQ_W-1:0]  seq;
    logic [BYTE_W-1:0] data_byte;
    logic [OFF_W-1:0]  byte_offset;
    logic [LEN_W-1:0]  pdu_length;
  } window_op_t;

  typedef struct packed {
    logic              status;
    logic [ACK_W-1:0]  ack_count;
    logic              window_open;
    logic [SEQ_W-1:0]  found_seq;
    logic [LEN_W-1:0]  found_length;
    logic [ATT_W-1:0]  attempt_count;
    logic [BYTE_W-1:0] data_out;
  } window_reply_t;

  logic clk;
  logic rst;

  arqsw_req_if req_if();
  arqsw_rsp_if rsp_if();
  arqsw_cfg_if cfg_if();

  arq_send_window dut (
    .clk(clk),
    .rst(rst),
    .cfg(cfg_if),
    .req(req_if),
    .rsp(rsp_if)
  );

  // shadow of the send window
  logic [WIN_W-1:0]  win_reg;
  logic [SEQ_W-1:0]  lo_seq;
  logic [SEQ_W-1:0]  nx_seq;
  int unsigned       lo_slot;
  logic              slot_live [SLOTS];
  logic [ATT_W-1:0]  slot_tries [SLOTS];
  logic [SEQ_W-1:0]  slot_seqno [SLOTS];
  logic [LEN_W-1:0]  slot_len [SLOTS];
  logic [BYTE_W-1:0] payload [SLOTS*PDU_BYTES];
  bit                byte_written [SLOTS*PDU_BYTES];

  window_op_t    ops_q[$];
  window_reply_t replies_due[$];
  window_op_t    cur_op;
  window_reply_t reply_now;
  bit            op_live;
  int unsigned   op_gap;
  int unsigned   rsp_wait;
  bit            steady;
  bit            cfg_pending;
  logic [WIN_W-1:0] cfg_value;
  int unsigned   n_pushed, n_accepted, n_results, n_found, n_cfg, n_mismatch;
  int unsigned   idle_cycles;

  initial begin
    rst = 1'b1;
    req_if.valid = 1'b0;
    req_if.mode = M_WRITE;
    req_if.seq = '0;
    req_if.data_byte = '0;
    req_if.byte_offset = '0;
    req_if.pdu_length = '0;
    rsp_if.ready = 1'b1;
    cfg_if.valid = 1'b0;
    cfg_if.window_size = WINDOW_RESET;
    cfg_value = WINDOW_RESET;
    win_reg = WINDOW_RESET;
    lo_seq = '0;
    nx_seq = '0;
    lo_slot = 0;
    foreach (slot_live[k]) begin
      slot_live[k] = 1'b0;
      slot_tries[k] = '0;
    end
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int unsigned eff_width();
    if (win_reg == 0) return 1;
    if (win_reg > SLOTS) return SLOTS;
    return win_reg;
  endfunction

  function automatic logic [63:0] upper_bound();
    return {32'b0, lo_seq} + 64'(eff_width());
  endfunction

  function automatic bit window_is_open();
    return {32'b0, nx_seq} < upper_bound();
  endfunction

  function automatic bit slot_lookup(input logic [MODE_W-1:0] mode,
                                     input logic [SEQ_W-1:0] s, output int unsigned idx);
    int unsigned w;
    w = eff_width();
    idx = 0;
    if (mode == M_READ_SEQ) begin
      if (s >= lo_seq && {32'b0, s} < upper_bound()) begin
        idx = s % w;
        return slot_live[idx] && slot_seqno[idx] == s;
      end
    end else if (mode == M_READ_LOW && lo_seq != nx_seq) begin
      idx = lo_slot % w;
      return slot_live[idx];
    end
    return 1'b0;
  endfunction

  function automatic window_reply_t advance_window(window_op_t op);
    window_reply_t r;
    int unsigned w, idx, n;
    r = '0;
    r.status = 1'b1;
    w = eff_width();
    case (op.mode)
      M_WRITE: begin
        if (window_is_open()) begin
          idx = (nx_seq % w) * PDU_BYTES + op.byte_offset;
          payload[idx] = op.data_byte;
          byte_written[idx] = 1'b1;
          r.status = 1'b0;
        end
      end
      M_COMMIT: begin
        if (op.pdu_length <= PDU_BYTES && op.seq == nx_seq && window_is_open()
            && nx_seq != '1) begin
          idx = nx_seq % w;
          slot_seqno[idx] = nx_seq;
          slot_len[idx] = op.pdu_length;
          slot_live[idx] = 1'b1;
          slot_tries[idx] = 1;
          nx_seq++;
          r.status = 1'b0;
        end
      end
      M_RR: begin
        if (op.seq <= lo_seq) begin
          r.status = 1'b0;
        end else if (op.seq <= nx_seq) begin
          n = op.seq - lo_seq;
          // a slide of a whole window or more empties every slot
          if (n >= w) begin
            foreach (slot_live[k]) slot_live[k] = 1'b0;
          end else begin
            for (int unsigned k = 0; k < n; k++) slot_live[(lo_seq + k) % w] = 1'b0;
          end
          lo_seq = op.seq;
          lo_slot = lo_seq % w;
          r.ack_count = ACK_W'(n > ACK_CAP ? ACK_CAP : n);
          r.status = 1'b0;
        end
      end
      M_SREJ: begin
        if (op.seq >= lo_seq && op.seq < nx_seq && {32'b0, op.seq} < upper_bound()) begin
          idx = op.seq % w;
          if (slot_live[idx] && slot_seqno[idx] == op.seq) begin
            if (slot_tries[idx] != ATT_MAX) slot_tries[idx]++;
            r.status = 1'b0;
          end
        end
      end
      M_READ_SEQ, M_READ_LOW: begin
        if (slot_lookup(op.mode, op.seq, idx)) begin
          r.found_seq = slot_seqno[idx];
          r.found_length = slot_len[idx];
          r.attempt_count = slot_tries[idx];
          r.data_out = payload[idx * PDU_BYTES + op.byte_offset];
          r.status = 1'b0;
        end
      end
      default: ;
    endcase
    r.window_open = window_is_open();
    return r;
  endfunction

  function automatic int unsigned draw_idle();
    if (steady) return 0;
    return $urandom_range(0, 14);
  endfunction

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      n_mismatch++;
    end
  endtask

  task automatic check_reply();
    window_reply_t want;
    if (replies_due.size() == 0) begin
      $error("result arrived with no request outstanding");
      n_mismatch++;
    end else begin
      want = replies_due.pop_front();
      n_results++;
      check_field("status", want.status, rsp_if.status);
      check_field("ack_count", want.ack_count, rsp_if.ack_count);
      check_field("window_open", want.window_open, rsp_if.window_open);
      check_field("found_seq", want.found_seq, rsp_if.found_seq);
      check_field("found_length", want.found_length, rsp_if.found_length);
      check_field("attempt_count", want.attempt_count, rsp_if.attempt_count);
      check_field("data_out", want.data_out, rsp_if.data_out);
    end
  endtask

  // request driver
  always @(posedge clk) begin
    if (!rst) begin
      if (req_if.valid && req_if.ready) begin
        reply_now = advance_window(cur_op);
        if (reply_now.status == 1'b0 &&
            (cur_op.mode == M_READ_SEQ || cur_op.mode == M_READ_LOW))
          n_found++;
        replies_due.push_back(reply_now);
        n_accepted++;
        op_live = 1'b0;
        op_gap = draw_idle();
      end
      if (!op_live) begin
        if (op_gap > 0) begin
          op_gap--;
        end else if (ops_q.size() != 0) begin
          cur_op = ops_q.pop_front();
          op_live = 1'b1;
          req_if.mode <= cur_op.mode;
          req_if.seq <= cur_op.seq;
          req_if.data_byte <= cur_op.data_byte;
          req_if.byte_offset <= cur_op.byte_offset;
          req_if.pdu_length <= cur_op.pdu_length;
        end
      end
      req_if.valid <= op_live;
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (!rst) begin
      if (rsp_if.valid && rsp_if.ready) begin
        check_reply();
        rsp_wait = draw_idle();
      end else if (rsp_wait > 0) begin
        rsp_wait--;
      end
      rsp_if.ready <= (rsp_wait == 0);
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_if.valid && cfg_if.ready) begin
        win_reg = cfg_if.window_size;
        lo_slot = lo_seq % eff_width();
        cfg_pending = 1'b0;
        n_cfg++;
      end
      cfg_if.valid <= cfg_pending;
      cfg_if.window_size <= cfg_value;
    end
  end

  always @(posedge clk) begin
    if (rst || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) ||
        (cfg_if.valid && cfg_if.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
  end

  initial begin
    idle_cycles = 0;
    wait (idle_cycles >= IDLE_LIMIT);
    $display("arq_send_window_tb NOT OK");
    $finish;
  end

  task automatic push_op(input logic [MODE_W-1:0] mode, input logic [SEQ_W-1:0] s,
                         input logic [BYTE_W-1:0] b, input logic [OFF_W-1:0] off,
                         input logic [LEN_W-1:0] len);
    window_op_t op;
    op = '{mode, s, b, off, len};
    ops_q.push_back(op);
    n_pushed++;
  endtask

  // shadow state is current once every queued request is taken
  task automatic wait_settled();
    while (n_accepted != n_pushed) @(negedge clk);
  endtask

  task automatic drain_replies();
    wait_settled();
    while (replies_due.size() != 0) @(negedge clk);
  endtask

  task automatic set_window(input logic [WIN_W-1:0] size);
    drain_replies();
    cfg_value = size;
    cfg_pending = 1'b1;
    while (cfg_pending) @(negedge clk);
  endtask

  // a read that hits a slot must land on a payload byte already written
  task automatic send_read(input logic [MODE_W-1:0] mode, input logic [SEQ_W-1:0] s,
                           input logic [OFF_W-1:0] off);
    int unsigned idx, k, pick;
    bit hit;
    if (slot_lookup(mode, s, idx) && !byte_written[idx * PDU_BYTES + off]) begin
      hit = 1'b0;
      pick = 0;
      for (k = 1; k < PDU_BYTES && !hit; k++) begin
        if (byte_written[idx * PDU_BYTES + (off + k) % PDU_BYTES]) begin
          pick = (off + k) % PDU_BYTES;
          hit = 1'b1;
        end
      end
      if (!hit) begin
        push_op(M_SREJ, s, $urandom, off, $urandom);
        return;
      end
      off = OFF_W'(pick);
    end
    push_op(mode, s, $urandom, off, $urandom);
  endtask

  // payload bytes followed by the commit; caller has settled the shadow state
  task automatic send_pdu(input bit force_ok);
    int unsigned n_bytes, k;
    logic [LEN_W-1:0] len;
    n_bytes = $urandom_range(1, 4);
    for (k = 0; k < n_bytes; k++)
      push_op(M_WRITE, $urandom, $urandom,
              ($urandom_range(0, 3) == 0) ? OFF_W'($urandom) : OFF_W'(k), $urandom);
    case ($urandom_range(0, 9))
      0: len = 0;
      1: len = PDU_BYTES;
      2: len = $urandom_range(0, PDU_BYTES);
      3: len = force_ok ? 16 : $urandom_range(PDU_BYTES + 1, 2**LEN_W - 1);
      default: len = $urandom_range(1, 8);
    endcase
    push_op(M_COMMIT, nx_seq, $urandom, $urandom, len);
  endtask

  task automatic random_action();
    int unsigned roll, span, w;
    logic [MODE_W-1:0] m;
    logic [SEQ_W-1:0] s;
    wait_settled();
    w = eff_width();
    span = nx_seq - lo_seq;
    roll = $urandom_range(0, 99);
    if (roll < 40) begin
      if (window_is_open()) send_pdu(1'b0);
      else push_op(M_RR, lo_seq + $urandom_range(1, span), $urandom, $urandom, $urandom);
    end else if (roll < 55) begin
      case ($urandom_range(0, 9))
        0: s = lo_seq - $urandom_range(0, lo_seq);
        1: s = nx_seq + $urandom_range(1, 3);
        2: s = $urandom;
        default: s = lo_seq + $urandom_range(0, span);
      endcase
      push_op(M_RR, s, $urandom, $urandom, $urandom);
    end else if (roll < 65) begin
      s = ($urandom_range(0, 4) == 0) ? $urandom : lo_seq + $urandom_range(0, span);
      push_op(M_SREJ, s, $urandom, $urandom, $urandom);
    end else if (roll < 80) begin
      s = ($urandom_range(0, 4) == 0) ? $urandom : lo_seq + $urandom_range(0, w);
      send_read(M_READ_SEQ, s, $urandom);
    end else if (roll < 88) begin
      send_read(M_READ_LOW, $urandom, $urandom);
    end else begin
      m = $urandom_range(0, 7);
      s = $urandom_range(0, 1) ? $urandom : lo_seq + $urandom_range(0, 3);
      if (m == M_READ_SEQ || m == M_READ_LOW) send_read(m, s, $urandom);
      else push_op(m, s, $urandom, $urandom, $urandom_range(0, 2**LEN_W - 1));
    end
  endtask

  function automatic logic [WIN_W-1:0] phase_window(input int unsigned p);
    case (p)
      0: return 7'd127;
      1: return 7'd8;
      2: return 7'd0;
      3: return 7'd64;
      4: return 7'd3;
      5: return 7'd100;
      6: return 7'd1;
      default: return $urandom_range(2, 63);
    endcase
  endfunction

  initial begin : stimulus
    int unsigned mark;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // empty window corners
    push_op(M_READ_LOW, 0, 0, 0, 0);
    push_op(M_RR, 0, 0, 0, 0);
    push_op(M_RR, 5, 0, 0, 0);
    push_op(M_SREJ, 0, 0, 0, 0);
    push_op(M_READ_SEQ, 0, 0, 0, 0);
    // payload extremes, bad commits, then two good PDUs
    push_op(M_WRITE, 0, 8'hFF, 0, 0);
    push_op(M_WRITE, 0, 8'h00, '1, 0);
    push_op(M_COMMIT, 1, 0, 0, 16);
    push_op(M_COMMIT, 0, 0, 0, PDU_BYTES + 1);
    push_op(M_COMMIT, 0, 0, 0, PDU_BYTES);
    push_op(M_WRITE, 0, 8'h5A, 0, 0);
    push_op(M_COMMIT, 1, 0, 0, 0);
    push_op(M_SREJ, 0, 0, 0, 0);
    push_op(M_READ_SEQ, 0, 0, '1, 0);
    push_op(M_READ_LOW, 0, 0, 0, 0);
    push_op(M_READ_SEQ, '1, 0, 0, 0);
    push_op(M_SPARE_LO, 0, 0, 0, 0);
    push_op(M_SPARE_HI, 0, 0, 0, 0);
    push_op(M_RR, 2, 0, 0, 0);

    // one-slot window: closes after a single commit
    set_window(7'd1);
    push_op(M_WRITE, 0, 8'h3C, 7, 0);
    push_op(M_COMMIT, 2, 0, 0, 16);
    push_op(M_WRITE, 0, 8'hC3, 0, 0);
    push_op(M_COMMIT, 3, 0, 0, 1);
    push_op(M_READ_LOW, 0, 0, 7, 0);
    push_op(M_RR, 3, 0, 0, 0);

    // drive one slot's attempt count into saturation
    set_window(WINDOW_RESET);
    wait_settled();
    if (!window_is_open()) push_op(M_RR, nx_seq, 0, 0, 0);
    wait_settled();
    send_pdu(1'b1);
    wait_settled();
    repeat (SREJ_BURST) push_op(M_SREJ, nx_seq - 1, $urandom, $urandom, $urandom);
    wait_settled();
    send_read(M_READ_SEQ, nx_seq - 1, 0);

    for (int unsigned p = 0; p < PHASES; p++) begin
      set_window(phase_window(p));
      steady = (p % 3 == 1);
      mark = n_pushed;
      while (n_pushed - mark < PHASE_OPS) random_action();
    end
    steady = 1'b0;

    drain_replies();
    repeat (20) @(negedge clk);
    $display("%0d requests issued, %0d results checked, %0d window size writes",
             n_accepted, n_results, n_cfg);
    $display("%0d slot reads found a stored PDU; lower edge ended at sequence %0d",
             n_found, lo_seq);
    if (n_mismatch == 0)
      $display("arq_send_window_tb OK");
    else
      $display("arq_send_window_tb NOT OK");
    $finish;
  end

endmodule
